FILE: rtl/rpc_frame_deframer_top_defines.svh
// Assertion macros shared by the deframer RTL.
`ifndef RPC_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define RPC_FRAME_DEFRAMER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define RFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/rfd_pkg.sv
package rfd_pkg;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_ERROR  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_BODY    = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_LEN_ERR = 2'd2
  } status_t;

  localparam logic [31:0] MAX_BODY_LEN_RESET = 32'd16777216;

  // header layout: 2 type bytes, 4 sequence bytes, 4 length bytes
  localparam logic [3:0] HDR_TYPE_END = 4'd2;
  localparam logic [3:0] HDR_SEQ_END  = 4'd6;
  localparam logic [3:0] HDR_LAST     = 4'd9;

endpackage

FILE: rtl/rfd_in_if.sv
interface rfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

FILE: rtl/rfd_out_if.sv
interface rfd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] message_type;
  logic [31:0] sequence_number;
  logic [31:0] body_length;
  logic [7:0]  body_byte;
  logic        last_of_frame;

  modport source (
    output valid, output status, output message_type, output sequence_number,
    output body_length, output body_byte, output last_of_frame, input ready
  );
  modport sink (
    input valid, input status, input message_type, input sequence_number,
    input body_length, input body_byte, input last_of_frame, output ready
  );
endinterface

FILE: rtl/rpc_frame_deframer_top.sv
// A result is registered: it appears on frame in the cycle after the byte that causes it.
// Throughput: one byte per cycle; the output register drains while the next
// byte is taken, so only a stalled, full output register holds the input off.
// Reset (rst, synchronous, active high): header phase, holds cleared, no result
// pending, max_body_length back to 16777216. A length error locks until reset.
`include "rpc_frame_deframer_top_defines.svh"

module rpc_frame_deframer_top
  import rfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  rfd_in_if.sink      stream,
  rfd_out_if.source   frame,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  logic [31:0] max_body_length;

  phase_t      phase, phase_next;
  logic [3:0]  header_count, header_count_next;
  logic [15:0] type_hold, type_hold_next;
  logic [31:0] sequence_hold, sequence_hold_next;
  logic [31:0] length_hold, length_hold_next;
  logic [31:0] bytes_remaining, bytes_remaining_next;

  logic        out_valid;
  status_t     out_status, res_status;
  logic [15:0] out_type;
  logic [31:0] out_seq, out_len;
  logic [7:0]  out_byte, res_byte;
  logic        out_last, res_last;
  logic        res_valid;

  logic        accept;
  logic [7:0]  b;

  assign stream.ready = !out_valid || frame.ready;
  assign accept       = stream.valid && stream.ready;
  assign b            = stream.stream_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_body_length <= MAX_BODY_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_body_length <= cfg_wr_data;
    end
  end

  always_comb begin
    phase_next           = phase;
    header_count_next    = header_count;
    type_hold_next       = type_hold;
    sequence_hold_next   = sequence_hold;
    length_hold_next     = length_hold;
    bytes_remaining_next = bytes_remaining;
    res_valid            = 1'b0;
    res_status           = ST_BODY;
    res_byte             = 8'd0;
    res_last             = 1'b0;
    unique case (phase)
      PH_HEADER: begin
        if (header_count < HDR_TYPE_END) begin
          type_hold_next = {type_hold[7:0], b};
        end else if (header_count < HDR_SEQ_END) begin
          sequence_hold_next = {sequence_hold[23:0], b};
        end else begin
          length_hold_next = {length_hold[23:0], b};
        end
        header_count_next = header_count + 4'd1;
        if (header_count == HDR_LAST) begin
          header_count_next = 4'd0;
          priority if (length_hold_next > max_body_length) begin
            phase_next = PH_ERROR;
            res_valid  = 1'b1;
            res_status = ST_LEN_ERR;
            res_last   = 1'b1;
          end else if (length_hold_next == 32'd0) begin
            res_valid  = 1'b1;
            res_status = ST_EMPTY;
            res_last   = 1'b1;
          end else begin
            bytes_remaining_next = length_hold_next;
            phase_next           = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        bytes_remaining_next = bytes_remaining - 32'd1;
        res_valid            = 1'b1;
        res_status           = ST_BODY;
        res_byte             = b;
        res_last             = (bytes_remaining == 32'd1);
        if (bytes_remaining == 32'd1) begin
          phase_next = PH_HEADER;
        end
      end
      default: begin
        // error lock: bytes are taken and dropped
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      header_count    <= 4'd0;
      type_hold       <= 16'd0;
      sequence_hold   <= 32'd0;
      length_hold     <= 32'd0;
      bytes_remaining <= 32'd0;
    end else if (accept) begin
      phase           <= phase_next;
      header_count    <= header_count_next;
      type_hold       <= type_hold_next;
      sequence_hold   <= sequence_hold_next;
      length_hold     <= length_hold_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && res_valid) begin
      out_valid <= 1'b1;
    end else if (frame.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_status <= res_status;
      out_type   <= type_hold_next;
      out_seq    <= sequence_hold_next;
      out_len    <= length_hold_next;
      out_byte   <= res_byte;
      out_last   <= res_last;
    end
  end

  assign frame.valid           = out_valid;
  assign frame.status          = out_status;
  assign frame.message_type    = out_type;
  assign frame.sequence_number = out_seq;
  assign frame.body_length     = out_len;
  assign frame.body_byte       = out_byte;
  assign frame.last_of_frame   = out_last;

  `RFD_ASSERT_NOW(a_count_idle, phase != PH_HEADER, header_count == 4'd0,
    "header count nonzero outside header phase")
  `RFD_ASSERT_NOW(a_body_nonzero, phase == PH_BODY, bytes_remaining != 32'd0,
    "body phase with no bytes remaining")
  `RFD_ASSERT_NOW(a_err_locks, out_valid && out_status == ST_LEN_ERR,
    phase == PH_ERROR, "length error result without error lock")
  `RFD_ASSERT_NEXT(a_body_result, accept && phase == PH_BODY, out_valid,
    "body byte transfer produced no result")

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
  import rfd_pkg::*;

  typedef struct {
    status_t     status;
    logic [15:0] message_type;
    logic [31:0] sequence_number;
    logic [31:0] body_length;
    logic [7:0]  body_byte;
    logic        last_of_frame;
  } frame_result_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_COMB
  } rx_mode_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [31:0] cfg_wr_data;

  rfd_in_if stream ();
  rfd_out_if frame ();

  rpc_frame_deframer_top uut (
    .clk        (clk),
    .rst        (rst),
    .stream     (stream),
    .frame      (frame),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // deframer mirror
  phase_t      parse_phase;
  logic [3:0]  hdr_count;
  logic [15:0] hold_type;
  logic [31:0] hold_seq;
  logic [31:0] hold_len;
  logic [31:0] body_left;
  logic [31:0] max_len_cfg;

  logic [7:0]    stream_bytes_q[$];
  frame_result_t deframed_q[$];
  int bytes_queued = 0;
  int bytes_taken = 0;
  int mismatches = 0;
  logic byte_taken = 1'b0;

  int burst_left = 1;
  int gap_left = 0;
  int ready_left = 0;
  rx_mode_t ready_mode = RX_OPEN;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic frame_result_t make_result(input status_t st, input logic [7:0] data,
                                                input logic last);
    frame_result_t r;
    r.status = st;
    r.message_type = hold_type;
    r.sequence_number = hold_seq;
    r.body_length = hold_len;
    r.body_byte = data;
    r.last_of_frame = last;
    return r;
  endfunction

  task automatic deframe_byte(input logic [7:0] b);
    case (parse_phase)
      PH_HEADER: begin
        if (hdr_count < HDR_TYPE_END) hold_type = {hold_type[7:0], b};
        else if (hdr_count < HDR_SEQ_END) hold_seq = {hold_seq[23:0], b};
        else hold_len = {hold_len[23:0], b};
        if (hdr_count != HDR_LAST) begin
          hdr_count++;
        end else begin
          hdr_count = '0;
          if (hold_len > max_len_cfg) begin
            parse_phase = PH_ERROR;
            deframed_q.push_back(make_result(ST_LEN_ERR, 8'h00, 1'b1));
          end else if (hold_len == 0) begin
            deframed_q.push_back(make_result(ST_EMPTY, 8'h00, 1'b1));
          end else begin
            body_left = hold_len;
            parse_phase = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        body_left--;
        deframed_q.push_back(make_result(ST_BODY, b, body_left == 0));
        if (body_left == 0) parse_phase = PH_HEADER;
      end
      default: ; // locked after a length error
    endcase
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic push_byte(input logic [7:0] b);
    stream_bytes_q.push_back(b);
    bytes_queued++;
  endtask

  task automatic queue_header(input logic [15:0] mtype, input logic [31:0] seq,
                              input logic [31:0] len);
    push_byte(mtype[15:8]);
    push_byte(mtype[7:0]);
    for (int i = 3; i >= 0; i--) push_byte(seq[i*8 +: 8]);
    for (int i = 3; i >= 0; i--) push_byte(len[i*8 +: 8]);
  endtask

  task automatic queue_random_frame(input logic [31:0] len);
    queue_header(16'($urandom()), $urandom(), len);
    for (int i = 0; i < len; i++) push_byte(8'($urandom_range(0, 255)));
  endtask

  // every queued byte taken and every result seen
  task automatic wait_idle();
    do @(negedge clk); while (bytes_taken != bytes_queued || deframed_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_max_length(input logic [31:0] value);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    max_len_cfg = value;
  endtask

  // sender: bursts of random length with random gaps
  always @(negedge clk) begin
    if (rst) begin
      stream.valid <= 1'b0;
      stream.stream_byte <= '0;
    end else if (stream.valid && !byte_taken) begin
      // hold the byte until its transfer
    end else if (gap_left != 0) begin
      gap_left--;
      stream.valid <= 1'b0;
    end else if (stream_bytes_q.size() != 0) begin
      stream.valid <= 1'b1;
      stream.stream_byte <= stream_bytes_q.pop_front();
      if (burst_left > 1) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 48);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end
    end else begin
      stream.valid <= 1'b0;
    end
  end

  // receiver: stall pattern switches mode at random
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode = rx_mode_t'($urandom_range(0, 3));
      ready_left = $urandom_range(8, 64);
    end else begin
      ready_left--;
    end
    case (ready_mode)
      RX_OPEN:   frame.ready <= 1'b1;
      RX_COIN:   frame.ready <= ($urandom_range(0, 1) == 0);
      RX_SPARSE: frame.ready <= ($urandom_range(0, 7) == 0);
      default:   frame.ready <= (ready_left[2:0] < 3'd5);
    endcase
  end

  // input transfers feed the mirror first, so a result never outruns its byte
  always @(posedge clk) begin
    frame_result_t want;
    if (rst) begin
      byte_taken = 1'b0;
    end else begin
      byte_taken = stream.valid && stream.ready;
      if (byte_taken) begin
        deframe_byte(stream.stream_byte);
        bytes_taken++;
      end
      if (frame.valid && frame.ready) begin
        if (deframed_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual status %h type %h seq %h",
                   $time, frame.status, frame.message_type, frame.sequence_number);
          mismatches++;
        end else begin
          want = deframed_q.pop_front();
          check_field("status", 32'(want.status), 32'(frame.status));
          check_field("message_type", 32'(want.message_type), 32'(frame.message_type));
          check_field("sequence_number", want.sequence_number, frame.sequence_number);
          check_field("body_length", want.body_length, frame.body_length);
          check_field("body_byte", 32'(want.body_byte), 32'(frame.body_byte));
          check_field("last_of_frame", 32'(want.last_of_frame), 32'(frame.last_of_frame));
        end
      end
    end
  end

  initial begin
    logic [31:0] limits[6];
    int phase_bytes;
    int top_len;
    int len;

    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    parse_phase = PH_HEADER;
    hdr_count = '0;
    hold_type = '0;
    hold_seq = '0;
    hold_len = '0;
    body_left = '0;
    max_len_cfg = MAX_BODY_LEN_RESET;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty frame with all-ones type, then a 2-byte body at the byte extremes
    queue_header(16'hFFFF, 32'h0000_0000, 32'd0);
    queue_header(16'h0000, 32'hFFFF_FFFF, 32'd2);
    push_byte(8'h00);
    push_byte(8'hFF);

    limits[0] = 32'hFFFF_FFFF;
    limits[1] = 32'd0;
    limits[2] = 32'd5;
    limits[3] = $urandom_range(1, 24);
    limits[4] = $urandom() | 32'h0000_0100;
    limits[5] = MAX_BODY_LEN_RESET;

    foreach (limits[p]) begin
      write_max_length(limits[p]);
      top_len = (max_len_cfg < 24) ? max_len_cfg : 24;
      phase_bytes = 0;
      while (phase_bytes < 200) begin
        len = ($urandom_range(0, 3) == 0) ? top_len : $urandom_range(0, top_len);
        queue_random_frame(len);
        phase_bytes += 10 + len;
      end
    end

    // one past the limit locks the block; trailing bytes must be dropped
    wait_idle();
    queue_header(16'($urandom()), $urandom(), max_len_cfg + 32'd1);
    for (int i = 0; i < 20; i++) push_byte(8'($urandom_range(0, 255)));

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && deframed_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
